FILE: rtl/rv64dec_pkg.sv
// Shared types, opcode and mnemonic codes, and funct3 lookup tables for the RV64I decoder.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps

package rv64dec_pkg;

	// Format type codes as seen on the format_type port.
	localparam logic [2:0] FT_ERR = 3'd0;
	localparam logic [2:0] FT_R   = 3'd1;
	localparam logic [2:0] FT_I   = 3'd2;
	localparam logic [2:0] FT_S   = 3'd3;
	localparam logic [2:0] FT_B   = 3'd4;
	localparam logic [2:0] FT_U   = 3'd5;
	localparam logic [2:0] FT_J   = 3'd6;

	// Major opcodes, bits 6:0 of the word.
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [6:0] OPC_OPIMMW = 7'b0011011;

	// funct3 values that pick special handling.
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SR  = 3'd5;

	// Mnemonic codes.
	localparam logic [5:0] MN_UNSUP  = 6'd0;
	localparam logic [5:0] MN_LUI    = 6'd1;
	localparam logic [5:0] MN_AUIPC  = 6'd2;
	localparam logic [5:0] MN_JAL    = 6'd3;
	localparam logic [5:0] MN_J      = 6'd4;
	localparam logic [5:0] MN_RET    = 6'd5;
	localparam logic [5:0] MN_JALR   = 6'd6;
	localparam logic [5:0] MN_BEQ    = 6'd7;
	localparam logic [5:0] MN_BNE    = 6'd8;
	localparam logic [5:0] MN_BLT    = 6'd9;
	localparam logic [5:0] MN_BGE    = 6'd10;
	localparam logic [5:0] MN_BLTU   = 6'd11;
	localparam logic [5:0] MN_BGEU   = 6'd12;
	localparam logic [5:0] MN_LB     = 6'd13;
	localparam logic [5:0] MN_LH     = 6'd14;
	localparam logic [5:0] MN_LW     = 6'd15;
	localparam logic [5:0] MN_LD     = 6'd16;
	localparam logic [5:0] MN_LBU    = 6'd17;
	localparam logic [5:0] MN_LHU    = 6'd18;
	localparam logic [5:0] MN_LWU    = 6'd19;
	localparam logic [5:0] MN_SB     = 6'd20;
	localparam logic [5:0] MN_SH     = 6'd21;
	localparam logic [5:0] MN_SW     = 6'd22;
	localparam logic [5:0] MN_SD     = 6'd23;
	localparam logic [5:0] MN_LI     = 6'd24;
	localparam logic [5:0] MN_ADDI   = 6'd25;
	localparam logic [5:0] MN_SLTI   = 6'd26;
	localparam logic [5:0] MN_SLTIU  = 6'd27;
	localparam logic [5:0] MN_XORI   = 6'd28;
	localparam logic [5:0] MN_ORI    = 6'd29;
	localparam logic [5:0] MN_ANDI   = 6'd30;
	localparam logic [5:0] MN_SLLI   = 6'd31;
	localparam logic [5:0] MN_SRLI   = 6'd32;
	localparam logic [5:0] MN_SRAI   = 6'd33;
	localparam logic [5:0] MN_ADD    = 6'd34;
	localparam logic [5:0] MN_SUB    = 6'd35;
	localparam logic [5:0] MN_SLL    = 6'd36;
	localparam logic [5:0] MN_SLT    = 6'd37;
	localparam logic [5:0] MN_SLTU   = 6'd38;
	localparam logic [5:0] MN_XOR    = 6'd39;
	localparam logic [5:0] MN_SRL    = 6'd40;
	localparam logic [5:0] MN_SRA    = 6'd41;
	localparam logic [5:0] MN_OR     = 6'd42;
	localparam logic [5:0] MN_AND    = 6'd43;
	localparam logic [5:0] MN_EBREAK = 6'd44;
	localparam logic [5:0] MN_ECALL  = 6'd45;
	localparam logic [5:0] MN_ADDIW  = 6'd46;
	localparam logic [5:0] MN_SLLIW  = 6'd47;
	localparam logic [5:0] MN_SRLIW  = 6'd48;
	localparam logic [5:0] MN_SRAIW  = 6'd49;

	// One decoded item.
	typedef struct packed {
		logic [2:0]  fmt;
		logic [5:0]  mn;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [63:0] imm;
	} dec_t;

	// Branch mnemonic by funct3; unused codes give MN_UNSUP.
	function automatic logic [5:0] branch_mn(input logic [2:0] f3);
		logic [5:0] mn;
		unique case (f3)
			3'd0:    mn = MN_BEQ;
			3'd1:    mn = MN_BNE;
			3'd4:    mn = MN_BLT;
			3'd5:    mn = MN_BGE;
			3'd6:    mn = MN_BLTU;
			3'd7:    mn = MN_BGEU;
			default: mn = MN_UNSUP;
		endcase
		return mn;
	endfunction

	// Load mnemonic by funct3.
	function automatic logic [5:0] load_mn(input logic [2:0] f3);
		logic [5:0] mn;
		unique case (f3)
			3'd0:    mn = MN_LB;
			3'd1:    mn = MN_LH;
			3'd2:    mn = MN_LW;
			3'd3:    mn = MN_LD;
			3'd4:    mn = MN_LBU;
			3'd5:    mn = MN_LHU;
			3'd6:    mn = MN_LWU;
			default: mn = MN_UNSUP;
		endcase
		return mn;
	endfunction

	// Store mnemonic by funct3.
	function automatic logic [5:0] store_mn(input logic [2:0] f3);
		logic [5:0] mn;
		unique case (f3)
			3'd0:    mn = MN_SB;
			3'd1:    mn = MN_SH;
			3'd2:    mn = MN_SW;
			3'd3:    mn = MN_SD;
			default: mn = MN_UNSUP;
		endcase
		return mn;
	endfunction

	// Register-immediate arithmetic by funct3, before the LI and SRAI overrides.
	function automatic logic [5:0] opimm_mn(input logic [2:0] f3);
		logic [5:0] mn;
		unique case (f3)
			3'd0: mn = MN_ADDI;
			3'd1: mn = MN_SLLI;
			3'd2: mn = MN_SLTI;
			3'd3: mn = MN_SLTIU;
			3'd4: mn = MN_XORI;
			3'd5: mn = MN_SRLI;
			3'd6: mn = MN_ORI;
			3'd7: mn = MN_ANDI;
		endcase
		return mn;
	endfunction

	// Register-register arithmetic by funct3, before the SUB and SRA overrides.
	function automatic logic [5:0] op_mn(input logic [2:0] f3);
		logic [5:0] mn;
		unique case (f3)
			3'd0: mn = MN_ADD;
			3'd1: mn = MN_SLL;
			3'd2: mn = MN_SLT;
			3'd3: mn = MN_SLTU;
			3'd4: mn = MN_XOR;
			3'd5: mn = MN_SRL;
			3'd6: mn = MN_OR;
			3'd7: mn = MN_AND;
		endcase
		return mn;
	endfunction

endpackage

FILE: rtl/rv64dec_core.sv
// Combinational decode of one RV64I word into a dec_t item.
// Depends on rv64dec_pkg for codes, tables and the dec_t type.
`timescale 1ns / 1ps

module rv64dec_core (
	input  logic [31:0]        word,
	input  logic [63:0]        addr,
	output rv64dec_pkg::dec_t  dec
);
	import rv64dec_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic        b30;
	logic [63:0] imm_i;
	logic [63:0] imm_s;
	logic [63:0] imm_b;
	logic [63:0] imm_u;
	logic [63:0] imm_j;
	logic [2:0]  lay;
	logic [5:0]  mn;

	assign opc = word[6:0];
	assign f3  = word[14:12];
	assign b30 = word[30];

	// Sign-extended immediates for each layout.
	assign imm_i = {{52{word[31]}}, word[31:20]};
	assign imm_s = {{52{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{51{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_u = {{32{word[31]}}, word[31:12], 12'b0};
	assign imm_j = {{43{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

	// Pick the layout and the mnemonic from opcode, funct3, bit 30 and, for some opcodes, the rd, rs1 or immediate field.
	always_comb begin
		lay = FT_ERR;
		mn  = MN_UNSUP;
		unique case (opc)
			OPC_LUI: begin
				lay = FT_U;
				mn  = MN_LUI;
			end
			OPC_AUIPC: begin
				lay = FT_U;
				mn  = MN_AUIPC;
			end
			OPC_JAL: begin
				lay = FT_J;
				mn  = (word[11:7] == 5'd0) ? MN_J : MN_JAL;
			end
			OPC_JALR: begin
				lay = FT_I;
				mn  = (word[11:7] == 5'd0) ? MN_RET : MN_JALR;
			end
			OPC_BRANCH: begin
				lay = FT_B;
				mn  = branch_mn(f3);
			end
			OPC_LOAD: begin
				lay = FT_I;
				mn  = load_mn(f3);
			end
			OPC_STORE: begin
				lay = FT_S;
				mn  = store_mn(f3);
			end
			OPC_OPIMM: begin
				lay = (f3 == F3_SLL || f3 == F3_SR) ? FT_R : FT_I;
				mn  = opimm_mn(f3);
				if (f3 == F3_ADD && word[19:15] == 5'd0) begin
					mn = MN_LI;
				end
				if (f3 == F3_SR && b30) begin
					mn = MN_SRAI;
				end
			end
			OPC_OP: begin
				lay = FT_R;
				mn  = op_mn(f3);
				if (b30 && f3 == F3_ADD) begin
					mn = MN_SUB;
				end
				if (b30 && f3 == F3_SR) begin
					mn = MN_SRA;
				end
			end
			OPC_SYSTEM: begin
				lay = FT_I;
				mn  = (word[31:20] != 12'd0) ? MN_EBREAK : MN_ECALL;
			end
			OPC_OPIMMW: begin
				if (f3 == F3_ADD) begin
					lay = FT_I;
					mn  = MN_ADDIW;
				end else begin
					lay = FT_R;
					if (f3 == F3_SLL) begin
						mn = MN_SLLIW;
					end else if (f3 == F3_SR) begin
						mn = b30 ? MN_SRAIW : MN_SRLIW;
					end
				end
			end
			default: begin
				lay = FT_ERR;
				mn  = MN_UNSUP;
			end
		endcase
	end

	// Extract the fields that the layout defines; the rest stay zero.
	// An unknown funct3 keeps the layout fields but reports an error format.
	always_comb begin
		dec     = '0;
		dec.mn  = mn;
		dec.fmt = (mn == MN_UNSUP) ? FT_ERR : lay;
		unique case (lay)
			FT_R: begin
				dec.rd  = word[11:7];
				dec.f3  = f3;
				dec.rs1 = word[19:15];
				dec.rs2 = word[24:20];
				dec.f7  = word[31:25];
			end
			FT_I: begin
				dec.rd  = word[11:7];
				dec.f3  = f3;
				dec.rs1 = word[19:15];
				dec.imm = imm_i;
			end
			FT_S: begin
				dec.f3  = f3;
				dec.rs1 = word[19:15];
				dec.rs2 = word[24:20];
				dec.imm = imm_s;
			end
			FT_B: begin
				dec.f3  = f3;
				dec.rs1 = word[19:15];
				dec.rs2 = word[24:20];
				dec.imm = imm_b;
			end
			FT_U: begin
				dec.rd  = word[11:7];
				dec.imm = imm_u;
			end
			FT_J: begin
				dec.rd  = word[11:7];
				// The J pseudo-instruction reports the absolute target.
				dec.imm = (mn == MN_J) ? (imm_j + addr) : imm_j;
			end
			default: begin
				dec.rd = 5'd0;
			end
		endcase
	end

endmodule

FILE: rtl/rv64i_instruction_decoder_unit.sv
// Top level of the RV64I decoder: input register, decode, output register, handshake.
// Depends on rv64dec_pkg and rv64dec_core.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   word    | word_valid, word_stall, instruction_word, | into block
//           | instruction_address                       |
//   dec     | dec_valid, dec_stall, format_type, ...    | out of block
//
// One item per cycle sustained while dec_stall is low; an accepted item passes
// through the input register, then the result register, to the outputs.
// Reset clears both valid flags; payload registers are not reset.
// A stall on the result channel holds the result register, and the input
// register takes at most one more item, then holds it and raises word_stall.
`timescale 1ns / 1ps

module rv64i_instruction_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               word_valid,
	output logic               word_stall,
	input  logic [31:0]        instruction_word,
	input  logic [63:0]        instruction_address,
	output logic               dec_valid,
	input  logic               dec_stall,
	output logic [2:0]         format_type,
	output logic [5:0]         mnemonic_code,
	output logic [4:0]         dest_reg,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [2:0]         func3_field,
	output logic [6:0]         func7_field,
	output logic signed [63:0] immediate
);
	import rv64dec_pkg::*;

	logic        valid_s1;
	logic [31:0] word_s1;
	logic [63:0] addr_s1;
	logic        valid_s2;
	dec_t        dec_s2;
	dec_t        dec_next;
	logic        accept;
	logic        load_s2;

	// Pipeline control: stage 2 loads from a valid stage 1 when empty or not stalled, stage 1 when empty or moving on.
	assign load_s2    = valid_s1 && (!valid_s2 || !dec_stall);
	assign word_stall = valid_s1 && !load_s2;
	assign accept     = word_valid && !word_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !load_s2);
			valid_s2 <= load_s2 || (valid_s2 && dec_stall);
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= instruction_word;
			addr_s1 <= instruction_address;
		end
	end

	rv64dec_core u_core (
		.word (word_s1),
		.addr (addr_s1),
		.dec  (dec_next)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (load_s2) begin
			dec_s2 <= dec_next;
		end
	end

	assign dec_valid     = valid_s2;
	assign format_type   = dec_s2.fmt;
	assign mnemonic_code = dec_s2.mn;
	assign dest_reg      = dec_s2.rd;
	assign src1_reg      = dec_s2.rs1;
	assign src2_reg      = dec_s2.rs2;
	assign func3_field   = dec_s2.f3;
	assign func7_field   = dec_s2.f7;
	assign immediate     = $signed(dec_s2.imm);

endmodule

FILE: rtl/rv64dec_checker.sv
// Port-level checks for the RV64I decoder, attached to the top level by bind.
// Depends on rv64dec_pkg for the format and mnemonic codes.
`timescale 1ns / 1ps

module rv64dec_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               dec_valid,
	input logic               dec_stall,
	input logic [2:0]         format_type,
	input logic [5:0]         mnemonic_code,
	input logic [4:0]         src1_reg,
	input logic [4:0]         src2_reg,
	input logic [2:0]         func3_field,
	input logic [6:0]         func7_field,
	input logic signed [63:0] immediate
);
	import rv64dec_pkg::*;

	// A stalled result item stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid)
		else $error("result item dropped while stalled");

	// A stalled result item keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> $stable(format_type) && $stable(mnemonic_code)
			&& $stable(immediate))
		else $error("result item changed while stalled");

	// The error format and the unsupported mnemonic always come together.
	a_err_pair: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid |-> ((format_type == FT_ERR) == (mnemonic_code == MN_UNSUP)))
		else $error("format and mnemonic disagree on error");

	// U and J layouts carry only rd and the immediate.
	a_uj_fields: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && (format_type == FT_U || format_type == FT_J)
			|-> src1_reg == 5'd0 && src2_reg == 5'd0 && func3_field == 3'd0
			&& func7_field == 7'd0)
		else $error("U or J item carries register or funct fields");

	// The R layout has no immediate.
	a_r_imm: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && format_type == FT_R |-> immediate == 64'sd0)
		else $error("R item carries an immediate");

endmodule

bind rv64i_instruction_decoder_unit rv64dec_checker u_rv64dec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.dec_valid     (dec_valid),
	.dec_stall     (dec_stall),
	.format_type   (format_type),
	.mnemonic_code (mnemonic_code),
	.src1_reg      (src1_reg),
	.src2_reg      (src2_reg),
	.func3_field   (func3_field),
	.func7_field   (func7_field),
	.immediate     (immediate)
);
